// ===== design/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg: shared types and constants of the frame receiver
// Codes, frame limits, queue word formats and the per-byte CRC16-CCITT update.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    // Frame limits
    localparam int DATA_CAPACITY       = 1024;
    localparam int COMPACT_MAX_PAYLOAD = 8;
    localparam int LEN_W               = $clog2(DATA_CAPACITY + 1);

    // Register map
    localparam int REG_FRAME_MODE = 0;

    // Input action codes
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Frame modes
    localparam logic MODE_CHECKED = 1'b0;
    localparam logic MODE_COMPACT = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_CRC_BAD   = 2'd2;

    localparam logic [7:0]  DELIM    = 8'h3A;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef logic [LEN_W-1:0] len_t;

    // Classified input word handed from front to back
    typedef struct packed {
        logic       flush;
        logic       delim;
        logic [7:0] data;
    } item_t;

    // Result word
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        logic [1:0]  frame_status;
    } result_t;

    // CRC16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/crcfr_front.sv =====
// ----------------------------------------------------------------------------
// crcfr_front: input side of the frame receiver
// Accepts received words, tags flush and delimiter, and holds them in a
// two-entry queue for the parser.
// ----------------------------------------------------------------------------
module crcfr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              action,
    input  logic [7:0]        rx_byte,
    output logic              item_valid,
    output crcfr_pkg::item_t  item,
    input  logic              item_take
);

    crcfr_pkg::item_t q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push_ok;
    crcfr_pkg::item_t in_item;

    assign full       = (count_reg == 2'd2);
    assign push_ok    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.flush = (action == crcfr_pkg::ACT_FLUSH);
        in_item.delim = (rx_byte == crcfr_pkg::DELIM);
        in_item.data  = rx_byte;
    end

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_ok} - {1'b0, item_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/crcfr_back.sv =====
// ----------------------------------------------------------------------------
// crcfr_back: frame parser and result queue
// Walks the frame phases, keeps the running CRC, and queues payload and
// frame-end words in a two-entry result queue.
// ----------------------------------------------------------------------------
module crcfr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_mode,
    input  logic               item_valid,
    input  crcfr_pkg::item_t   item,
    output logic               item_take,
    output logic               empty,
    input  logic               pop,
    output crcfr_pkg::result_t result
);

    typedef enum logic [2:0]
    {
        PH_HUNT,
        PH_CMD,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [7:0]          len_hi_reg, len_hi_next;
    crcfr_pkg::len_t     ann_reg, ann_next;
    crcfr_pkg::len_t     seen_reg, seen_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          crc_hi_reg, crc_hi_next;

    crcfr_pkg::result_t  res_q_reg [2];
    logic                res_wr_reg, res_wr_next;
    logic                res_rd_reg, res_rd_next;
    logic [1:0]          res_count_reg, res_count_next;

    logic                compact;
    logic                emit;
    logic                clear;
    logic                go_cmd;
    crcfr_pkg::result_t  res;
    logic [7:0]          b;
    logic [15:0]         len16;
    logic [crcfr_pkg::LEN_W:0] seen_inc;
    logic                last_byte;
    logic                res_pop;

    assign compact   = (frame_mode == crcfr_pkg::MODE_COMPACT);
    assign item_take = item_valid && (res_count_reg != 2'd2);
    assign b         = item.data;
    assign len16     = {len_hi_reg, b};
    assign seen_inc  = {1'b0, seen_reg} + 1'b1;
    assign last_byte = (seen_inc >= {1'b0, ann_reg});

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        len_hi_next = len_hi_reg;
        ann_next    = ann_reg;
        seen_next   = seen_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        emit        = 1'b0;
        clear       = 1'b0;
        go_cmd      = 1'b0;

        res.kind          = crcfr_pkg::KIND_END;
        res.payload_byte  = 8'd0;
        res.byte_index    = 10'd0;
        res.frame_command = cmd_reg;
        res.frame_length  = 16'(ann_reg);
        res.frame_status  = crcfr_pkg::ST_OK;

        if (item_take)
        begin
            if (item.flush)
            begin
                clear = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (item.delim)
                        begin
                            clear  = 1'b1;
                            go_cmd = 1'b1;
                        end
                    end
                    PH_CMD:
                    begin
                        cmd_next   = b;
                        crc_next   = crcfr_pkg::crc_byte(crcfr_pkg::CRC_INIT, b);
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        if (!compact)
                        begin
                            len_hi_next = b;
                            crc_next    = crcfr_pkg::crc_byte(crc_reg, b);
                            phase_next  = PH_LEN_LO;
                        end
                        else if (b > 8'(crcfr_pkg::COMPACT_MAX_PAYLOAD))
                        begin
                            emit             = 1'b1;
                            res.frame_length = {8'd0, b};
                            res.frame_status = crcfr_pkg::ST_TOO_LARGE;
                            clear            = 1'b1;
                        end
                        else if (b == 8'd0)
                        begin
                            emit             = 1'b1;
                            res.frame_length = 16'd0;
                            clear            = 1'b1;
                        end
                        else
                        begin
                            ann_next   = crcfr_pkg::len_t'(b);
                            seen_next  = '0;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        if (compact)
                        begin
                            clear = 1'b1;
                        end
                        else if (len16 > 16'(crcfr_pkg::DATA_CAPACITY))
                        begin
                            emit             = 1'b1;
                            res.frame_length = len16;
                            res.frame_status = crcfr_pkg::ST_TOO_LARGE;
                            clear            = 1'b1;
                        end
                        else
                        begin
                            crc_next   = crcfr_pkg::crc_byte(crc_reg, b);
                            ann_next   = crcfr_pkg::len_t'(len16);
                            seen_next  = '0;
                            phase_next = (len16 == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        emit             = 1'b1;
                        res.payload_byte = b;
                        res.byte_index   = 10'(seen_reg);
                        if (compact && last_byte)
                        begin
                            // last compact byte rides on the frame-end word
                            clear = 1'b1;
                        end
                        else
                        begin
                            res.kind  = crcfr_pkg::KIND_PAYLOAD;
                            seen_next = seen_inc[crcfr_pkg::LEN_W-1:0];
                            if (!compact)
                            begin
                                crc_next = crcfr_pkg::crc_byte(crc_reg, b);
                                if (last_byte)
                                begin
                                    phase_next = PH_CRC_HI;
                                end
                            end
                        end
                    end
                    PH_CRC_HI:
                    begin
                        if (compact)
                        begin
                            clear = 1'b1;
                        end
                        else
                        begin
                            crc_hi_next = b;
                            phase_next  = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO:
                    begin
                        clear = 1'b1;
                        if (!compact)
                        begin
                            emit             = 1'b1;
                            res.frame_status = ({crc_hi_reg, b} == crc_reg) ?
                                               crcfr_pkg::ST_OK : crcfr_pkg::ST_CRC_BAD;
                        end
                    end
                    default:
                    begin
                        clear = 1'b1;
                    end
                endcase
            end
        end

        if (clear)
        begin
            phase_next  = go_cmd ? PH_CMD : PH_HUNT;
            cmd_next    = 8'd0;
            len_hi_next = 8'd0;
            ann_next    = '0;
            seen_next   = '0;
            crc_next    = crcfr_pkg::CRC_INIT;
            crc_hi_next = 8'd0;
        end
    end

    // Result queue
    assign empty   = (res_count_reg == 2'd0);
    assign res_pop = pop && !empty;
    assign result  = res_q_reg[res_rd_reg];

    always_comb
    begin
        res_wr_next    = emit ? ~res_wr_reg : res_wr_reg;
        res_rd_next    = res_pop ? ~res_rd_reg : res_rd_reg;
        res_count_next = res_count_reg + {1'b0, emit} - {1'b0, res_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            cmd_reg       <= 8'd0;
            len_hi_reg    <= 8'd0;
            ann_reg       <= '0;
            seen_reg      <= '0;
            crc_reg       <= crcfr_pkg::CRC_INIT;
            crc_hi_reg    <= 8'd0;
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            len_hi_reg    <= len_hi_next;
            ann_reg       <= ann_next;
            seen_reg      <= seen_next;
            crc_reg       <= crc_next;
            crc_hi_reg    <= crc_hi_next;
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_q_reg[res_wr_reg] <= res;
        end
    end

endmodule

// ===== design/crc_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// crc_frame_receiver_top: byte-stream frame receiver with CRC16 check
//
//   channel   handshake        payload
//   input     push / full      action, rx_byte
//   result    empty / pop      result_kind, payload_byte, byte_index,
//                              frame_command, frame_length, frame_status
//   config    APB write/read   frame_mode at byte address 0
//
// One word per cycle sustained while results are popped; the parser takes one
// word a cycle from the input queue while the result queue has room, with the
// CRC byte update as one XOR network per word. A result is registered in the
// result queue at the edge on which the parser takes its word. rst_n clears
// the parser, both queues and frame_mode at once. A stalled result side fills
// the result queue, then the input queue, then raises full.
// ----------------------------------------------------------------------------
module crc_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [9:0]  byte_index,
    output logic [7:0]  frame_command,
    output logic [15:0] frame_length,
    output logic [1:0]  frame_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               frame_mode_reg, frame_mode_next;
    logic               cfg_wr;
    logic               reg_sel;
    logic               item_valid;
    logic               item_take;
    crcfr_pkg::item_t   item;
    crcfr_pkg::result_t result;

    // Configuration
    assign pready  = 1'b1;
    assign reg_sel = (32'(paddr[2]) == 32'(crcfr_pkg::REG_FRAME_MODE));
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {31'd0, frame_mode_reg} : 32'd0;

    always_comb
    begin
        frame_mode_next = cfg_wr ? pwdata[0] : frame_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= crcfr_pkg::MODE_CHECKED;
        end
        else
        begin
            frame_mode_reg <= frame_mode_next;
        end
    end

    crcfr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    crcfr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_mode (frame_mode_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign result_kind   = result.kind;
    assign payload_byte  = result.payload_byte;
    assign byte_index    = result.byte_index;
    assign frame_command = result.frame_command;
    assign frame_length  = result.frame_length;
    assign frame_status  = result.frame_status;

`ifndef NO_ASSERTIONS
    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> item_valid)
        else $error("parser took a word from an empty input queue");

    a_payload_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == crcfr_pkg::KIND_PAYLOAD) |-> frame_status == crcfr_pkg::ST_OK)
        else $error("payload word carries a nonzero status");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue filled without a push");

    a_result_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(item_take))
        else $error("result appeared without a parsed word");
`endif

endmodule
